// ===== rtl/bwhr_pkg.sv =====
// Package for the banked work RAM and high RAM block.
// Holds the address map, region codes and the pipeline request type.
// No dependencies.
package bwhr_pkg;

	localparam int BANK_BYTES     = 4096;
	localparam int OFFSET_BITS    = 12;
	localparam int HIGH_RAM_BYTES = 127;
	localparam int HRAM_AW        = 7;
	localparam int BANK_SEL_BITS  = 3;

	localparam logic [15:0] BANK_REG_ADDR = 16'hFF70;
	localparam logic [15:0] HRAM_FIRST    = 16'hFF80;
	localparam logic [15:0] HRAM_LAST     = 16'hFFFE;
	localparam logic [15:0] ECHO_LAST     = 16'hFDFF;
	localparam logic [3:0]  NIB_WRAM0     = 4'hC;
	localparam logic [3:0]  NIB_WRAMX     = 4'hD;
	localparam logic [3:0]  NIB_ECHO0     = 4'hE;
	localparam logic [3:0]  NIB_ECHOX     = 4'hF;

	localparam logic [7:0] UNCLAIMED_DATA = 8'hFF;
	localparam logic [7:0] WRITE_DATA_OUT = 8'h00;
	localparam logic [4:0] BANK_RB_FILL   = 5'h1F;

	typedef enum logic [1:0] {
		RGN_NONE = 2'd0,
		RGN_WRAM = 2'd1,
		RGN_HRAM = 2'd2,
		RGN_BANK = 2'd3
	} region_t;

	typedef struct packed {
		logic                     is_write;
		region_t                  region;
		logic [BANK_SEL_BITS-1:0] bank_rb;
	} req_t;

	function automatic region_t decode_region(input logic [15:0] addr);
		region_t r;
		r = RGN_NONE;
		if (addr[15:12] == NIB_WRAM0 || addr[15:12] == NIB_WRAMX ||
		    addr[15:12] == NIB_ECHO0) begin
			r = RGN_WRAM;
		end else if (addr[15:12] == NIB_ECHOX && addr <= ECHO_LAST) begin
			r = RGN_WRAM;
		end else if (addr >= HRAM_FIRST && addr <= HRAM_LAST) begin
			r = RGN_HRAM;
		end else if (addr == BANK_REG_ADDR) begin
			r = RGN_BANK;
		end
		return r;
	endfunction

endpackage

// ===== rtl/bwhr_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module bwhr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/banked_work_ram_and_high_ram_top.sv =====
// Banked work RAM (bank 0 plus a switchable bank) and high RAM on a CPU bus.
// An accepted item is registered in stage 1 (RAM read) and then in the output register;
// one item per cycle sustained while in_stall is low. Reads hold in the RAM output
// register while the result stage is stalled.
// Reset clears the bank register, then a sweep over all BANK_COUNT*4096 addresses
// (32768 at the default) zeroes both RAMs, with in_stall high for its whole length.
module banked_work_ram_and_high_ram_top
	import bwhr_pkg::*;
#(
	parameter int BANK_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        claimed
);

	localparam int BW     = $clog2(BANK_COUNT);
	localparam int WDEPTH = BANK_COUNT * BANK_BYTES;
	localparam int WAW    = BW + OFFSET_BITS;
	localparam logic [3:0] BANK_CNT4 = 4'(BANK_COUNT);

	logic                     clr_busy_q;
	logic [WAW-1:0]           clr_cnt_q;
	logic [BANK_SEL_BITS-1:0] bank_sel_q;
	logic [BW-1:0]            bank_eff_q;
	logic [3:0]               bank_map;

	logic    accept, adv_s1, valid_s1;
	req_t    req_s1;
	region_t rgn;

	logic           wram_we, wram_re;
	logic [WAW-1:0] wram_addr, wram_waddr;
	logic [7:0]     wram_wdata, wram_rdata;
	logic [BW-1:0]  bank_idx;

	logic               hram_we, hram_re;
	logic [HRAM_AW-1:0] hram_waddr;
	logic [7:0]         hram_wdata, hram_rdata;

	logic       out_valid_q, claimed_q;
	logic [7:0] read_data_q;
	logic [7:0] rd_s1;

	assign adv_s1   = !out_valid_q || !out_stall;
	assign in_stall = clr_busy_q || (valid_s1 && !adv_s1);
	assign accept   = in_valid && !in_stall;
	assign rgn      = decode_region(address);

	// bank 0 maps to bank 1, then folded into the banks that exist
	always_comb begin
		bank_map = (write_data[BANK_SEL_BITS-1:0] == '0) ? 4'd1
		           : {1'b0, write_data[BANK_SEL_BITS-1:0]};
		for (int i = 0; i < 3; i++) begin
			if (bank_map >= BANK_CNT4) begin
				bank_map = bank_map - BANK_CNT4;
			end
		end
	end

	// address bit 12 splits the fixed bank (C/E) from the switchable one (D/F)
	assign bank_idx  = address[OFFSET_BITS] ? bank_eff_q : '0;
	assign wram_addr = {bank_idx, address[OFFSET_BITS-1:0]};

	always_comb begin
		if (clr_busy_q) begin
			wram_we    = 1'b1;
			wram_waddr = clr_cnt_q;
			wram_wdata = '0;
			hram_we    = (clr_cnt_q < WAW'(HIGH_RAM_BYTES));
			hram_waddr = clr_cnt_q[HRAM_AW-1:0];
			hram_wdata = '0;
		end else begin
			wram_we    = accept && command && rgn == RGN_WRAM;
			wram_waddr = wram_addr;
			wram_wdata = write_data;
			hram_we    = accept && command && rgn == RGN_HRAM;
			hram_waddr = address[HRAM_AW-1:0];
			hram_wdata = write_data;
		end
	end

	assign wram_re = accept && !command && rgn == RGN_WRAM;
	assign hram_re = accept && !command && rgn == RGN_HRAM;

	bwhr_ram #(.WIDTH(8), .DEPTH(WDEPTH)) u_wram (
		.clk   (clk),
		.we    (wram_we),
		.waddr (wram_waddr),
		.wdata (wram_wdata),
		.re    (wram_re),
		.raddr (wram_addr),
		.rdata (wram_rdata)
	);

	bwhr_ram #(.WIDTH(8), .DEPTH(HIGH_RAM_BYTES)) u_hram (
		.clk   (clk),
		.we    (hram_we),
		.waddr (hram_waddr),
		.wdata (hram_wdata),
		.re    (hram_re),
		.raddr (address[HRAM_AW-1:0]),
		.rdata (hram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == WAW'(WDEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_sel_q <= '0;
			bank_eff_q <= BW'(1);
		end else if (accept && command && rgn == RGN_BANK) begin
			bank_sel_q <= write_data[BANK_SEL_BITS-1:0];
			bank_eff_q <= bank_map[BW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.is_write <= command;
			req_s1.region   <= rgn;
			req_s1.bank_rb  <= bank_sel_q;
		end
	end

	always_comb begin
		case (req_s1.region)
			RGN_NONE: rd_s1 = UNCLAIMED_DATA;
			RGN_WRAM: rd_s1 = wram_rdata;
			RGN_HRAM: rd_s1 = hram_rdata;
			RGN_BANK: rd_s1 = {BANK_RB_FILL, req_s1.bank_rb};
			default:  rd_s1 = UNCLAIMED_DATA;
		endcase
		if (req_s1.is_write) begin
			rd_s1 = WRITE_DATA_OUT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			read_data_q <= rd_s1;
			claimed_q   <= (req_s1.region != RGN_NONE);
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign claimed   = claimed_q;

	a_bank_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(bank_eff_q) < BANK_COUNT)
		else $error("switchable bank index out of range");

	a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !valid_s1 && !out_valid_q)
		else $error("item in flight during clearing sweep");

	a_rdata_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> $stable(wram_rdata) && $stable(hram_rdata))
		else $error("RAM read data lost while result stage stalled");

	a_unclaimed_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !claimed_q) |->
			(read_data_q == UNCLAIMED_DATA || read_data_q == WRITE_DATA_OUT))
		else $error("unclaimed item carries stored data");

endmodule
